FILE: rtl/nbg_pkg.sv
// ----------------------------------------------------------------------------
// nbg_pkg
// types and constants shared by the n-body gravity step block
// ----------------------------------------------------------------------------
package nbg_pkg;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgGravity   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgBodyCount = 1'b1;

  localparam logic [31:0] GravityReset   = 32'd655360;
  localparam logic [2:0]  BodyCountReset = 3'd3;

  typedef struct packed {
    logic               mode;
    logic [1:0]         body_index;
    logic signed [31:0] load_pos_x;
    logic signed [31:0] load_pos_y;
    logic signed [31:0] load_vel_x;
    logic signed [31:0] load_vel_y;
    logic [31:0]        load_mass;
    logic               load_affected;
  } nbg_in_t;

  typedef struct packed {
    logic [1:0]         out_index;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
    logic               last_body;
  } nbg_out_t;

  function automatic logic signed [31:0] sat_add32(logic signed [31:0] a,
                                                   logic signed [33:0] b);
    logic signed [34:0] s;
    s = 35'(a) + 35'(b);
    if (s > 35'sd2147483647) return 32'sh7fffffff;
    else if (s < -35'sd2147483648) return 32'sh80000000;
    else return s[31:0];
  endfunction

endpackage

FILE: rtl/nbody_gravity_step.sv
// ----------------------------------------------------------------------------
// nbody_gravity_step
// direct all-pairs gravity with semi-implicit euler update over a body memory
// ----------------------------------------------------------------------------
// channel | direction | handshake         | payload
// cmd     | in        | start, busy       | cmd_i (nbg_in_t)
// result  | out       | res_valid_o       | res_o (nbg_out_t)
// cfg     | in        | cfg_valid_i/ready | cfg_index_i, cfg_data_i
//
// a load is written in its transfer cycle and busy stays low. a step reads a
// pair (prdi, prdj, pcap); a pair with no affected body ends there, else the
// square and a 34-step root (a zero root ends the pair), l cubed, a select per
// body and, per affected body of nonzero mass, half-width multiplies and a
// 128-step divider per axis; then each body is read and output (ord, owait, out).
// reset sets state and config to defaults and clears result valid and the
// per-body valid bits; invalid bodies read 0. results cannot be stalled.
module nbody_gravity_step #(
  parameter int unsigned MAX_BODIES = 4,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  nbg_pkg::nbg_in_t        cmd_i,
  output logic                    res_valid_o,
  output nbg_pkg::nbg_out_t       res_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [nbg_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]             cfg_data_i
);
  import nbg_pkg::*;

  localparam int unsigned IW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
  localparam int unsigned EW = 32 * 5 + 1;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_PRDI  = 5'd1;
  localparam logic [4:0] S_PRDJ  = 5'd2;
  localparam logic [4:0] S_PCAP  = 5'd3;
  localparam logic [4:0] S_SQ    = 5'd4;
  localparam logic [4:0] S_SQRT  = 5'd5;
  localparam logic [4:0] S_L2    = 5'd6;
  localparam logic [4:0] S_L3    = 5'd7;
  localparam logic [4:0] S_PSEL  = 5'd8;
  localparam logic [4:0] S_GM    = 5'd9;
  localparam logic [4:0] S_NUM   = 5'd10;
  localparam logic [4:0] S_DIV   = 5'd11;
  localparam logic [4:0] S_ACC   = 5'd12;
  localparam logic [4:0] S_WB    = 5'd13;
  localparam logic [4:0] S_ORD   = 5'd14;
  localparam logic [4:0] S_OWAIT = 5'd15;
  localparam logic [4:0] S_OUT   = 5'd16;
  localparam logic [4:0] S_NEXT  = 5'd17;

  // body memory entry: pos x, pos y, vel x, vel y, mass, affected
  logic [EW-1:0] mem_q [MAX_BODIES];
  logic [MAX_BODIES-1:0] vld_q;
  logic [EW-1:0] rdat_q;
  logic          rvld_q;
  logic [IW-1:0] raddr;
  logic          we;
  logic [IW-1:0] waddr;
  logic [EW-1:0] wdat;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdat;
    rdat_q <= mem_q[raddr];
    rvld_q <= vld_q[raddr];
  end

  logic [4:0]    state_q;
  logic [31:0]   grav_q;
  logic [2:0]    cnt_q;
  logic [IW-1:0] bi_q, bj_q, k_q;
  logic [EW-1:0] ei_q, ej_q;
  logic [IW:0]   n_w;
  logic signed [32:0] dx_q, dy_q;
  logic [65:0]   s_q;
  logic [33:0]   l_q;
  logic [5:0]    it_q;
  logic [67:0]   l2_q;
  logic [101:0]  l3_q;
  logic          side_q, axis_q;
  logic          ph_q;
  logic [63:0]   gm_q;
  logic [127:0]  num_q, quo_q;
  logic [128:0]  rem_q;
  logic [6:0]    dit_q;
  logic          dneg_q;
  logic signed [31:0] vx_q, vy_q;
  logic          res_valid_q;
  nbg_out_t      res_q;

  function automatic logic [31:0] fx(input logic [EW-1:0] e, input int unsigned f);
    return e[EW-1-32*f -: 32];
  endfunction

  always_comb begin
    if (cnt_q < 3'd2) n_w = (IW+1)'(2);
    else if (32'(cnt_q) > MAX_BODIES) n_w = (IW+1)'(MAX_BODIES);
    else n_w = (IW+1)'(cnt_q);
  end

  logic [IW:0] bj1, bi1, k1;
  assign bj1 = {1'b0, bj_q} + 1'b1;
  assign bi1 = {1'b0, bi_q} + 1'b1;
  assign k1  = {1'b0, k_q} + 1'b1;

  logic [EW-1:0] self_e, oth_e;
  assign self_e = side_q ? ej_q : ei_q;
  assign oth_e  = side_q ? ei_q : ej_q;
  logic signed [32:0] dsel;
  assign dsel = axis_q ? (side_q ? -dy_q : dy_q) : (side_q ? -dx_q : dx_q);
  logic [32:0] dabs;
  assign dabs = dsel[32] ? 33'(-dsel) : 33'(dsel);

  // partial products, low half first
  logic [67:0] l3_part;
  assign l3_part = (ph_q ? l2_q[67:34] : l2_q[33:0]) * l_q;
  logic [64:0] num_part;
  assign num_part = (ph_q ? gm_q[63:32] : gm_q[31:0]) * dabs;

  logic [33:0]  sq_c;
  logic [67:0]  sq_cc;
  assign sq_c  = l_q | (34'd1 << it_q);
  assign sq_cc = 68'(sq_c) * 68'(sq_c);

  logic [128:0] rem_sh;
  assign rem_sh = {rem_q[127:0], num_q[7'(dit_q)]};

  logic signed [33:0] amag;
  always_comb begin
    logic [33:0] m;
    m = (quo_q > 128'h1_0000_0000) ? 34'h1_0000_0000 : {1'b0, quo_q[32:0]};
    amag = dneg_q ? -$signed(m) : $signed(m);
  end

  assign busy = state_q != S_IDLE;
  assign cfg_ready_o = 1'b1;
  assign res_valid_o = res_valid_q;
  assign res_o = res_q;

  logic [EW-1:0] rd_e;
  assign rd_e = rvld_q ? rdat_q : '0;

  always_comb begin
    raddr = k_q;
    unique case (state_q)
      S_PRDI: raddr = bi_q;
      S_PRDJ: raddr = bj_q;
      default: raddr = k_q;
    endcase
    we = 1'b0;
    waddr = side_q ? bj_q : bi_q;
    wdat = {fx(self_e,0), fx(self_e,1), vx_q, vy_q, fx(self_e,4), self_e[0]};
    if (state_q == S_IDLE && start && !cmd_i.mode) begin
      we = 32'(cmd_i.body_index) < MAX_BODIES;
      waddr = IW'(cmd_i.body_index);
      wdat = {cmd_i.load_pos_x, cmd_i.load_pos_y, cmd_i.load_vel_x,
              cmd_i.load_vel_y, cmd_i.load_mass, cmd_i.load_affected};
    end else if (state_q == S_WB) begin
      we = 1'b1;
    end else if (state_q == S_OUT) begin
      we = 1'b1;
      waddr = k_q;
      wdat = {res_q.out_pos_x, res_q.out_pos_y, fx(ei_q,2), fx(ei_q,3),
              fx(ei_q,4), ei_q[0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      grav_q <= GravityReset;
      cnt_q <= BodyCountReset;
      vld_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgGravity:   grav_q <= cfg_data_i;
          CfgBodyCount: cnt_q <= cfg_data_i[2:0];
          default: ;
        endcase
      end
      if (we) vld_q[waddr] <= 1'b1;
      unique case (state_q)
        S_IDLE: if (start) begin
          if (cmd_i.mode) begin
            bi_q <= '0; bj_q <= IW'(1); state_q <= S_PRDI;
          end
        end
        S_PRDI: state_q <= S_PRDJ;
        S_PRDJ: begin ei_q <= rd_e; state_q <= S_PCAP; end
        S_PCAP: begin
          ej_q <= rd_e;
          dx_q <= $signed({rd_e[EW-1], fx(rd_e,0)}) - $signed({ei_q[EW-1], fx(ei_q,0)});
          dy_q <= $signed({rd_e[EW-33], fx(rd_e,1)}) - $signed({ei_q[EW-33], fx(ei_q,1)});
          if (!ei_q[0] && !rd_e[0]) state_q <= S_NEXT;
          else state_q <= S_SQ;
        end
        S_SQ: begin
          s_q <= 66'(($signed(dx_q) * $signed(dx_q))) + 66'(($signed(dy_q) * $signed(dy_q)));
          l_q <= '0; it_q <= 6'd33; state_q <= S_SQRT;
        end
        S_SQRT: begin
          if ({2'b0, sq_cc} <= 70'(s_q)) l_q <= sq_c;
          if (it_q == 6'd0) state_q <= S_L2;
          else it_q <= it_q - 1'b1;
        end
        S_L2: begin
          if (l_q == '0) state_q <= S_NEXT;
          else begin
            l2_q <= 68'(l_q) * 68'(l_q); ph_q <= 1'b0; state_q <= S_L3;
          end
        end
        S_L3: begin
          if (!ph_q) begin
            l3_q <= 102'(l3_part); ph_q <= 1'b1;
          end else begin
            l3_q <= l3_q + {l3_part, 34'd0}; ph_q <= 1'b0;
            side_q <= 1'b0; axis_q <= 1'b0; state_q <= S_PSEL;
          end
        end
        S_PSEL: begin
          if (!self_e[0] || fx(self_e,4) == '0) begin
            if (side_q) state_q <= S_NEXT;
            else side_q <= 1'b1;
          end else begin
            vx_q <= $signed(fx(self_e,2)); vy_q <= $signed(fx(self_e,3));
            axis_q <= 1'b0; state_q <= S_GM;
          end
        end
        S_GM: begin gm_q <= 64'(grav_q) * 64'(fx(oth_e,4)); state_q <= S_NUM; end
        S_NUM: begin
          if (!ph_q) begin
            num_q <= 128'(num_part) << FRAC_BITS; ph_q <= 1'b1;
          end else begin
            num_q <= num_q + (128'(num_part) << (32 + FRAC_BITS));
            ph_q <= 1'b0;
            dneg_q <= dsel[32];
            rem_q <= '0; quo_q <= '0; dit_q <= 7'd127; state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_sh >= 129'(l3_q)) begin
            rem_q <= rem_sh - 129'(l3_q); quo_q <= {quo_q[126:0], 1'b1};
          end else begin
            rem_q <= rem_sh; quo_q <= {quo_q[126:0], 1'b0};
          end
          if (dit_q == 7'd0) state_q <= S_ACC;
          else dit_q <= dit_q - 1'b1;
        end
        S_ACC: begin
          if (!axis_q) begin
            vx_q <= sat_add32(vx_q, amag); axis_q <= 1'b1; state_q <= S_NUM;
          end else begin
            vy_q <= sat_add32(vy_q, amag); state_q <= S_WB;
          end
        end
        S_WB: begin
          if (side_q) begin
            ej_q <= wdat; state_q <= S_NEXT;
          end else begin
            ei_q <= wdat; side_q <= 1'b1; state_q <= S_PSEL;
          end
        end
        S_NEXT: begin
          if (bj1 < n_w) begin bj_q <= bj1[IW-1:0]; state_q <= S_PRDI; end
          else if (bi1 + 1'b1 < n_w) begin
            bi_q <= bi1[IW-1:0]; bj_q <= IW'(bi1 + 1'b1); state_q <= S_PRDI;
          end else begin k_q <= '0; state_q <= S_ORD; end
        end
        S_ORD: state_q <= S_OWAIT;
        S_OWAIT: begin
          ei_q <= rd_e;
          res_q.out_index <= 2'(k_q);
          res_q.out_pos_x <= sat_add32($signed(fx(rd_e,0)), 34'($signed(fx(rd_e,2))));
          res_q.out_pos_y <= sat_add32($signed(fx(rd_e,1)), 34'($signed(fx(rd_e,3))));
          res_q.out_vel_x <= $signed(fx(rd_e,2));
          res_q.out_vel_y <= $signed(fx(rd_e,3));
          res_q.last_body <= k1 == n_w;
          res_valid_q <= 1'b1;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (k1 == n_w) state_q <= S_IDLE;
          else begin k_q <= k1[IW-1:0]; state_q <= S_ORD; end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_res_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy) else $error("result outside a step");
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o) else $error("results back to back");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last_body |=> !busy) else $error("step did not end");
`endif

endmodule
